### rtl/ttzs_pkg.sv
package ttzs_pkg;

    // Number of time bins in one anode readout.
    localparam int TIME_BINS = 128;

    // Window padding around a kept run.
    localparam int EXTRA_BEFORE = 1;
    localparam int EXTRA_AFTER  = 3;

    localparam logic [7:0] COUNT_MAX = 8'd255;
    localparam logic [6:0] KEPT_MAX  = 7'd127;

    // Configuration register indexes (byte address divided by four).
    localparam logic [1:0] REG_LOW_THRESHOLD  = 2'd0;
    localparam logic [1:0] REG_HIGH_THRESHOLD = 2'd1;
    localparam logic [1:0] REG_MIN_LOW_COUNT  = 2'd2;
    localparam logic [1:0] REG_MIN_HIGH_COUNT = 2'd3;

    localparam logic [7:0] LOW_THRESHOLD_RST  = 8'd26;
    localparam logic [7:0] HIGH_THRESHOLD_RST = 8'd30;
    localparam logic [7:0] MIN_LOW_COUNT_RST  = 8'd2;
    localparam logic [7:0] MIN_HIGH_COUNT_RST = 8'd0;

    typedef struct packed {
        logic [7:0] sample_adc;
        logic [6:0] time_bin;
        logic [7:0] anode;
        logic       first_of_anode;
        logic       last_of_segment;
    } t_sample;

    typedef struct packed {
        logic [7:0] out_anode;
        logic [6:0] window_start;
        logic [7:0] window_length;
        logic [6:0] window_number;
    } t_window;

endpackage

### rtl/ttzs_stream_if.sv
interface ttzs_stream_if #(
    parameter type T = logic
);
    logic valid;
    logic ready;
    T     payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

### rtl/two_threshold_zero_suppression.sv
// Dual-threshold zero suppression. One ADC sample is accepted per clock and held in an input
// register. The run and high-sample counter updates are computed from it combinationally. When it
// closes a run that passes both minimum counts, one window request is loaded into the output
// register as the sample advances and is offered to the receiver from there. Sustained rate is
// one sample per cycle as long as the receiver takes every waiting window. While a window waits
// to be taken, the sample in the input register cannot move on, so the input takes at most one
// more sample and then stalls. A new sample can enter in the same cycle as the waiting window
// is taken. The thresholds and minimum counts sit at byte addresses 0, 4, 8 and 12 of the APB
// port and must only be written while no sample is in flight.
module two_threshold_zero_suppression #(
    parameter int TIME_BINS = ttzs_pkg::TIME_BINS
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    ttzs_stream_if.sink                   i_samples,
    ttzs_stream_if.source                 o_windows,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [3:0]                    paddr,
    input  logic [31:0]                   pwdata,
    output logic [31:0]                   prdata,
    output logic                          pready
);
    import ttzs_pkg::*;

    localparam int CALC_W = 11;

    logic [7:0] r_low_threshold;
    logic [7:0] r_high_threshold;
    logic [7:0] r_min_low_count;
    logic [7:0] r_min_high_count;

    logic        r_in_valid;
    t_sample     r_in;
    logic        r_out_valid;
    t_window     r_out;

    logic [7:0] r_run_count;
    logic [7:0] r_high_count;
    logic [6:0] r_run_first_bin;
    logic [6:0] r_kept_count;

    logic [7:0] n_run_count;
    logic [7:0] n_high_count;
    logic [6:0] n_run_first_bin;
    logic [6:0] n_kept_count;
    t_window    n_out;

    logic        w_advance;
    logic        w_keep;
    logic        w_above_low;
    logic        w_ends;
    logic [7:0]  w_run_base;
    logic [7:0]  w_high_base;
    logic [6:0]  w_kept_base;
    logic [7:0]  w_run_new;
    logic [7:0]  w_high_new;
    logic [6:0]  w_start;
    logic [CALC_W-1:0] w_start_ext;
    logic [CALC_W-1:0] w_len_raw;
    logic [CALC_W-1:0] w_len_clip;
    logic        w_cfg_write;

    // ---------------------------------------------------------------- configuration
    assign pready      = 1'b1;
    assign w_cfg_write = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_low_threshold  <= LOW_THRESHOLD_RST;
            r_high_threshold <= HIGH_THRESHOLD_RST;
            r_min_low_count  <= MIN_LOW_COUNT_RST;
            r_min_high_count <= MIN_HIGH_COUNT_RST;
        end else if (w_cfg_write) begin
            unique case (paddr[3:2])
                REG_LOW_THRESHOLD:  r_low_threshold  <= pwdata[7:0];
                REG_HIGH_THRESHOLD: r_high_threshold <= pwdata[7:0];
                REG_MIN_LOW_COUNT:  r_min_low_count  <= pwdata[7:0];
                REG_MIN_HIGH_COUNT: r_min_high_count <= pwdata[7:0];
                default:            r_low_threshold  <= r_low_threshold;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[3:2])
            REG_LOW_THRESHOLD:  prdata = {24'd0, r_low_threshold};
            REG_HIGH_THRESHOLD: prdata = {24'd0, r_high_threshold};
            REG_MIN_LOW_COUNT:  prdata = {24'd0, r_min_low_count};
            REG_MIN_HIGH_COUNT: prdata = {24'd0, r_min_high_count};
            default:            prdata = 32'd0;
        endcase
    end

    // ---------------------------------------------------------------- handshake
    assign w_advance       = r_in_valid && (!r_out_valid || o_windows.ready);
    assign i_samples.ready = !r_in_valid || w_advance;
    assign o_windows.valid = r_out_valid;
    assign o_windows.payload = r_out;

    // ---------------------------------------------------------------- run tracking
    always_comb begin
        // A new anode discards any open run before this sample is looked at.
        w_run_base  = r_in.first_of_anode ? 8'd0 : r_run_count;
        w_high_base = r_in.first_of_anode ? 8'd0 : r_high_count;
        w_kept_base = r_in.first_of_anode ? 7'd0 : r_kept_count;

        w_above_low     = r_in.sample_adc > r_low_threshold;
        w_run_new       = w_run_base;
        w_high_new      = w_high_base;
        n_run_first_bin = r_run_first_bin;
        if (w_above_low) begin
            if (w_run_base == 8'd0) begin
                n_run_first_bin = r_in.time_bin;
            end
            if (w_run_base != COUNT_MAX) begin
                w_run_new = w_run_base + 8'd1;
            end
            if (r_in.sample_adc > r_high_threshold && w_high_base != COUNT_MAX) begin
                w_high_new = w_high_base + 8'd1;
            end
        end
        w_ends = !w_above_low || r_in.last_of_segment;
        w_keep = w_ends && (w_run_new > r_min_low_count) && (w_high_new > r_min_high_count);

        // Window edges: one bin of margin before, three after, clipped to the bin count.
        w_start     = (n_run_first_bin >= 7'(EXTRA_BEFORE)) ?
                      n_run_first_bin - 7'(EXTRA_BEFORE) : 7'd0;
        w_start_ext = CALC_W'(w_start);
        w_len_raw   = CALC_W'(w_run_new) + CALC_W'(EXTRA_BEFORE + EXTRA_AFTER);
        if (w_start_ext >= CALC_W'(TIME_BINS)) begin
            w_len_clip = '0;
        end else if (w_len_raw + w_start_ext > CALC_W'(TIME_BINS)) begin
            w_len_clip = CALC_W'(TIME_BINS) - w_start_ext;
        end else begin
            w_len_clip = w_len_raw;
        end

        n_out.out_anode     = r_in.anode;
        n_out.window_start  = w_start;
        n_out.window_length = (w_len_clip > CALC_W'(COUNT_MAX)) ? COUNT_MAX : w_len_clip[7:0];
        n_out.window_number = w_kept_base;

        n_run_count  = w_ends ? 8'd0 : w_run_new;
        n_high_count = w_ends ? 8'd0 : w_high_new;
        n_kept_count = (w_keep && w_kept_base != KEPT_MAX) ? w_kept_base + 7'd1 : w_kept_base;
    end

    // ---------------------------------------------------------------- registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid      <= 1'b0;
            r_out_valid     <= 1'b0;
            r_run_count     <= 8'd0;
            r_high_count    <= 8'd0;
            r_run_first_bin <= 7'd0;
            r_kept_count    <= 7'd0;
        end else begin
            if (i_samples.ready) begin
                r_in_valid <= i_samples.valid;
            end
            if (w_advance) begin
                r_out_valid     <= w_keep;
                r_run_count     <= n_run_count;
                r_high_count    <= n_high_count;
                r_run_first_bin <= n_run_first_bin;
                r_kept_count    <= n_kept_count;
            end else if (o_windows.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_samples.ready && i_samples.valid) begin
            r_in <= i_samples.payload;
        end
        if (w_advance && w_keep) begin
            r_out <= n_out;
        end
    end

endmodule

### bench/testbench.sv
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import ttzs_pkg::*;

    logic        i_clk;
    logic        i_rst_n;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [3:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    ttzs_stream_if #(.T(t_sample)) samples_if ();
    ttzs_stream_if #(.T(t_window)) windows_if ();

    two_threshold_zero_suppression dut (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_samples (samples_if),
        .o_windows (windows_if),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready)
    );

    // Shadow copy of the thresholds and minimum counts.
    logic [7:0] cfg_low      = LOW_THRESHOLD_RST;
    logic [7:0] cfg_high     = HIGH_THRESHOLD_RST;
    logic [7:0] cfg_min_low  = MIN_LOW_COUNT_RST;
    logic [7:0] cfg_min_high = MIN_HIGH_COUNT_RST;

    // Run tracking state of the window predictor.
    logic [7:0] run_len       = '0;
    logic [7:0] high_len      = '0;
    logic [6:0] run_start_bin = '0;
    logic [6:0] kept_windows  = '0;

    t_window pending_windows[$];
    int      mismatches    = 0;
    int      samples_sent  = 0;
    int      windows_seen  = 0;
    int      config_phases = 0;
    int      hold_cycles   = 0;
    bit      steady        = 1'b0;

    initial begin
        i_clk = 1'b0;
    end

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    initial begin
        #5ms;
        $display("Run timed out with %0d windows still pending", pending_windows.size());
        $display("FAILURE");
        $finish;
    end

    function automatic t_sample mk_sample(input int adc, input int bin, input int anode_no,
                                          input int first, input int last);
        t_sample s;
        s.sample_adc      = adc[7:0];
        s.time_bin        = bin[6:0];
        s.anode           = anode_no[7:0];
        s.first_of_anode  = first[0];
        s.last_of_segment = last[0];
        return s;
    endfunction

    task automatic predict_window(input t_sample s);
        t_window w;
        logic    closes;
        int      start_bin;
        int      win_len;
        if (s.first_of_anode) begin
            kept_windows = '0;
            run_len      = '0;
            high_len     = '0;
        end
        if (s.sample_adc > cfg_low) begin
            if (run_len == 0) begin
                run_start_bin = s.time_bin;
            end
            if (run_len != COUNT_MAX) begin
                run_len++;
            end
            if (s.sample_adc > cfg_high && high_len != COUNT_MAX) begin
                high_len++;
            end
            closes = s.last_of_segment;
        end else begin
            closes = 1'b1;
        end
        if (closes) begin
            if (run_len > cfg_min_low && high_len > cfg_min_high) begin
                start_bin = (run_start_bin >= EXTRA_BEFORE) ? run_start_bin - EXTRA_BEFORE : 0;
                win_len   = run_len + EXTRA_BEFORE + EXTRA_AFTER;
                if (start_bin >= TIME_BINS) begin
                    win_len = 0;
                end else if (win_len + start_bin > TIME_BINS) begin
                    win_len = TIME_BINS - start_bin;
                end
                if (win_len > 255) begin
                    win_len = 255;
                end
                w.out_anode     = s.anode;
                w.window_start  = start_bin[6:0];
                w.window_length = win_len[7:0];
                w.window_number = kept_windows;
                pending_windows.push_back(w);
                if (kept_windows != KEPT_MAX) begin
                    kept_windows++;
                end
            end
            run_len  = '0;
            high_len = '0;
        end
    endtask

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (want !== got) begin
            $error("%s mismatch: expected %0d, actual %0d", name, want, got);
            mismatches++;
        end
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n && samples_if.valid && samples_if.ready) begin
            predict_window(samples_if.payload);
        end
    end

    always @(posedge i_clk) begin
        t_window want;
        if (i_rst_n && windows_if.valid && windows_if.ready) begin
            windows_seen++;
            if (pending_windows.size() == 0) begin
                $error("Window request for anode %0d arrived with none expected",
                       windows_if.payload.out_anode);
                mismatches++;
            end else begin
                want = pending_windows.pop_front();
                check_field("out_anode", 32'(want.out_anode),
                            32'(windows_if.payload.out_anode));
                check_field("window_start", 32'(want.window_start),
                            32'(windows_if.payload.window_start));
                check_field("window_length", 32'(want.window_length),
                            32'(windows_if.payload.window_length));
                check_field("window_number", 32'(want.window_number),
                            32'(windows_if.payload.window_number));
            end
        end
    end

    // Receiver side: random stalls, a stall-free mode and a counted hold-off.
    initial begin
        windows_if.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_cycles > 0) begin
                windows_if.ready = 1'b0;
                hold_cycles--;
            end else if (steady) begin
                windows_if.ready = 1'b1;
            end else begin
                windows_if.ready = ($urandom_range(99) >= 20);
            end
        end
    end

    task automatic send_sample(input t_sample s);
        @(negedge i_clk);
        while (!steady && $urandom_range(99) < 20) begin
            samples_if.valid = 1'b0;
            @(negedge i_clk);
        end
        samples_if.valid   = 1'b1;
        samples_if.payload = s;
        do @(posedge i_clk); while (!samples_if.ready);
        samples_sent++;
    endtask

    // Lets every pending window drain, then waits out a sample that closed no run.
    task automatic settle();
        int guard;
        @(negedge i_clk);
        samples_if.valid = 1'b0;
        guard = 0;
        while (pending_windows.size() != 0 && guard < 5000) begin
            @(posedge i_clk);
            guard++;
        end
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [1:0] index, input logic [7:0] value);
        @(negedge i_clk);
        psel    = 1'b1;
        penable = 1'b0;
        pwrite  = 1'b1;
        paddr   = {index, 2'b00};
        pwdata  = {24'd0, value};
        @(negedge i_clk);
        penable = 1'b1;
        do @(posedge i_clk); while (!pready);
        case (index)
            REG_LOW_THRESHOLD:  cfg_low      = value;
            REG_HIGH_THRESHOLD: cfg_high     = value;
            REG_MIN_LOW_COUNT:  cfg_min_low  = value;
            REG_MIN_HIGH_COUNT: cfg_min_high = value;
            default: ;
        endcase
        // Read the register straight back.
        @(negedge i_clk);
        penable = 1'b0;
        pwrite  = 1'b0;
        @(negedge i_clk);
        penable = 1'b1;
        do @(posedge i_clk); while (!pready);
        check_field("prdata", {24'd0, value}, prdata);
        @(negedge i_clk);
        psel    = 1'b0;
        penable = 1'b0;
    endtask

    task automatic set_config(input logic [7:0] low, input logic [7:0] high,
                              input logic [7:0] min_low, input logic [7:0] min_high);
        settle();
        write_reg(REG_LOW_THRESHOLD, low);
        write_reg(REG_HIGH_THRESHOLD, high);
        write_reg(REG_MIN_LOW_COUNT, min_low);
        write_reg(REG_MIN_HIGH_COUNT, min_high);
        config_phases++;
    endtask

    // Reset settings: window edges, clipping, anode restart and runs that fall short.
    task automatic run_directed();
        send_sample(mk_sample(255, 0, 1, 1, 0));
        send_sample(mk_sample(27, 1, 1, 0, 0));
        send_sample(mk_sample(31, 2, 1, 0, 0));
        send_sample(mk_sample(26, 3, 1, 0, 0));
        send_sample(mk_sample(0, 4, 1, 0, 0));
        send_sample(mk_sample(200, 124, 1, 0, 0));
        send_sample(mk_sample(200, 125, 1, 0, 0));
        send_sample(mk_sample(200, 126, 1, 0, 0));
        send_sample(mk_sample(200, 127, 1, 0, 1));
        // An open run is dropped when the next anode starts.
        send_sample(mk_sample(100, 10, 1, 0, 0));
        send_sample(mk_sample(100, 11, 1, 0, 0));
        send_sample(mk_sample(100, 12, 240, 1, 0));
        send_sample(mk_sample(100, 13, 240, 0, 0));
        send_sample(mk_sample(100, 14, 240, 0, 1));
        send_sample(mk_sample(50, 20, 240, 0, 0));
        send_sample(mk_sample(50, 21, 240, 0, 0));
        send_sample(mk_sample(0, 22, 240, 0, 0));
        // Above the low threshold but never above the high one.
        send_sample(mk_sample(27, 30, 240, 0, 0));
        send_sample(mk_sample(28, 31, 240, 0, 0));
        send_sample(mk_sample(30, 32, 240, 0, 0));
        send_sample(mk_sample(29, 33, 240, 0, 1));
    endtask

    task automatic run_register_extremes();
        set_config(8'd0, 8'd255, 8'd0, 8'd0);
        send_sample(mk_sample(255, 5, 17, 1, 0));
        send_sample(mk_sample(255, 6, 17, 0, 0));
        send_sample(mk_sample(0, 7, 17, 0, 0));
        send_sample(mk_sample(1, 8, 17, 0, 1));
        set_config(8'd0, 8'd0, 8'd0, 8'd0);
        send_sample(mk_sample(1, 0, 85, 1, 0));
        send_sample(mk_sample(0, 1, 85, 0, 0));
        send_sample(mk_sample(128, 127, 85, 0, 1));
        set_config(8'd255, 8'd255, 8'd128, 8'd128);
        send_sample(mk_sample(255, 10, 170, 1, 0));
        send_sample(mk_sample(255, 11, 170, 0, 1));
    endtask

    // Runs around the largest minimum count, and one long enough to saturate the counters.
    task automatic run_long_runs();
        set_config(8'd0, 8'd0, 8'd128, 8'd128);
        for (int i = 0; i < 129; i++) begin
            send_sample(mk_sample(255, (3 + i) % 128, 200, int'(i == 0), 0));
        end
        send_sample(mk_sample(0, 4, 200, 0, 0));
        for (int i = 0; i < 128; i++) begin
            send_sample(mk_sample(254, i, 200, 0, 0));
        end
        send_sample(mk_sample(0, 0, 200, 0, 0));
        for (int i = 0; i < 300; i++) begin
            send_sample(mk_sample(129, (60 + i) % 128, 201, 0, int'(i == 299)));
        end
    endtask

    // Every sample closes a kept run, so numbering saturates; the receiver holds off meanwhile.
    task automatic run_window_numbering();
        set_config(8'd26, 8'd30, 8'd0, 8'd0);
        hold_cycles = 300;
        for (int i = 0; i < 140; i++) begin
            send_sample(mk_sample($urandom_range(255, 31), $urandom_range(127), 99,
                                  int'(i == 0), 1));
        end
    endtask

    task automatic send_random_anode(inout int count);
        int anode_no;
        int segments;
        int seg_len;
        int first_bin;
        int pulse_left;
        int adc;
        anode_no   = $urandom_range(240, 1);
        segments   = $urandom_range(3, 1);
        pulse_left = 0;
        for (int seg = 0; seg < segments; seg++) begin
            seg_len   = ($urandom_range(15) == 0) ? 128 : $urandom_range(40, 4);
            first_bin = $urandom_range(128 - seg_len);
            for (int b = 0; b < seg_len; b++) begin
                if (pulse_left == 0 && $urandom_range(4) == 0) begin
                    pulse_left = $urandom_range(10, 1);
                end
                if (pulse_left > 0 && cfg_low != 8'd255) begin
                    if ($urandom_range(1) == 0 && cfg_high != 8'd255) begin
                        adc = $urandom_range(255, cfg_high + 1);
                    end else begin
                        adc = $urandom_range(255, cfg_low + 1);
                    end
                    pulse_left--;
                end else begin
                    adc = $urandom_range(cfg_low);
                    pulse_left = 0;
                end
                if ($urandom_range(9) == 0) begin
                    send_sample(mk_sample($urandom_range(255), $urandom_range(127),
                                          $urandom_range(240, 1), $urandom_range(1),
                                          $urandom_range(1)));
                end else begin
                    send_sample(mk_sample(adc, first_bin + b, anode_no,
                                          int'(seg == 0 && b == 0),
                                          int'(b == seg_len - 1)));
                end
                count++;
            end
        end
    endtask

    task automatic run_random_streams();
        int         count;
        logic [7:0] low;
        for (int phase = 0; phase < 6; phase++) begin
            low = 8'($urandom_range(100));
            set_config(low, 8'($urandom_range(low + 80, low)), 8'($urandom_range(6)),
                       8'($urandom_range(4)));
            steady = (phase == 2);
            count  = 0;
            while (count < 170) begin
                send_random_anode(count);
            end
        end
        steady = 1'b0;
    endtask

    initial begin
        i_rst_n            = 1'b0;
        samples_if.valid   = 1'b0;
        samples_if.payload = '0;
        psel               = 1'b0;
        penable            = 1'b0;
        pwrite             = 1'b0;
        paddr              = '0;
        pwdata             = '0;
        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        run_directed();
        run_register_extremes();
        run_long_runs();
        run_window_numbering();
        run_random_streams();

        settle();
        if (pending_windows.size() != 0) begin
            $error("%0d expected windows never arrived", pending_windows.size());
            mismatches++;
        end
        $display("Sent %0d samples and checked %0d windows over %0d register settings,",
                 samples_sent, windows_seen, config_phases);
        $display("including clipped and saturated windows, anode restarts and a stalled output.");
        if (mismatches == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule
